>>> hdl/uart_rx_filtering_ring_buffer_unit_macros.svh
// ----------------------------------------------------------------------------
// uart rx ring buffer assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef UART_RX_FILTERING_RING_BUFFER_UNIT_MACROS_SVH
`define UART_RX_FILTERING_RING_BUFFER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define URX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define URX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/urx_rb_pkg.sv
// ----------------------------------------------------------------------------
// urx_rb_pkg
// constants, codes and control types of the uart rx ring buffer
// ----------------------------------------------------------------------------
package urx_rb_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int FILL_W     = 9;

  // request kinds
  localparam logic [1:0] KIND_RECEIVE = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  // special characters
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // request accepted this cycle
    logic fetch_done;  // stored character is in the read register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // no stored characters
    logic out_busy;  // result register holds a result not taken this cycle
  } dp_status_t;

endpackage

>>> hdl/urx_rb_ctrl.sv
// ----------------------------------------------------------------------------
// urx_rb_ctrl
// request sequencer: requests taken in ST_IDLE; ST_FETCH follows a stored read
// ----------------------------------------------------------------------------
module urx_rb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_kind,
  output logic                   in_ready,
  input  urx_rb_pkg::dp_status_t status,
  output urx_rb_pkg::dp_cmd_t    cmd
);

  urx_rb_pkg::state_t state_r;
  urx_rb_pkg::state_t state_nxt;
  logic               take;

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= urx_rb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      urx_rb_pkg::ST_IDLE: begin
        if (take && (in_kind == urx_rb_pkg::KIND_READ) && !status.empty) begin
          state_nxt = urx_rb_pkg::ST_FETCH;
        end
      end
      urx_rb_pkg::ST_FETCH: begin
        state_nxt = urx_rb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = urx_rb_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.take       = 1'b0;
    cmd.fetch_done = 1'b0;
    case (state_r)
      urx_rb_pkg::ST_IDLE: begin
        in_ready = !status.out_busy;
        cmd.take = take;
      end
      urx_rb_pkg::ST_FETCH: begin
        cmd.fetch_done = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/urx_rb_dp.sv
// ----------------------------------------------------------------------------
// urx_rb_dp
// character store, pointers, count, line flag and result register
// ----------------------------------------------------------------------------
module urx_rb_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  urx_rb_pkg::dp_cmd_t    cmd,
  output urx_rb_pkg::dp_status_t status,
  input  logic [1:0]             in_kind,
  input  logic [7:0]             in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_read_char,
  output logic                   out_read_valid,
  output logic                   out_line_flag,
  output logic [8:0]             out_fill_level,
  output logic                   out_overflow
);

  localparam logic [urx_rb_pkg::PTR_W-1:0] PTR_LAST =
    urx_rb_pkg::PTR_W'(urx_rb_pkg::RING_DEPTH - 1);
  localparam logic [urx_rb_pkg::CNT_W-1:0] CNT_FULL =
    urx_rb_pkg::CNT_W'(urx_rb_pkg::RING_DEPTH);

  logic [7:0] mem [urx_rb_pkg::RING_DEPTH];

  logic [urx_rb_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [urx_rb_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [urx_rb_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                         line_r, line_nxt;
  logic [7:0]                   rd_data_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_rvalid_r, out_rvalid_nxt;
  logic       out_flag_r, out_flag_nxt;
  logic [8:0] out_fill_r, out_fill_nxt;
  logic       out_ovf_r, out_ovf_nxt;

  logic       mem_we;
  logic       mem_re;
  logic [7:0] filtered;
  logic       is_full;

  assign filtered = (in_rx_byte == urx_rb_pkg::CH_TAB) ? urx_rb_pkg::CH_SPACE : in_rx_byte;
  assign is_full  = (count_r == CNT_FULL);

  assign status.empty    = (count_r == '0);
  assign status.out_busy = out_valid_r && !out_ready;

  always_comb begin
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    count_nxt      = count_r;
    line_nxt       = line_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_char_nxt   = out_char_r;
    out_rvalid_nxt = out_rvalid_r;
    out_flag_nxt   = out_flag_r;
    out_fill_nxt   = out_fill_r;
    out_ovf_nxt    = out_ovf_r;

    if (cmd.take) begin
      out_char_nxt   = 8'd0;
      out_rvalid_nxt = 1'b0;
      out_ovf_nxt    = 1'b0;
      out_valid_nxt  = 1'b1;
      case (in_kind)
        urx_rb_pkg::KIND_RECEIVE: begin
          if (in_rx_byte != urx_rb_pkg::CH_RETURN) begin
            if (is_full) begin
              out_ovf_nxt = 1'b1;
            end else begin
              mem_we     = 1'b1;
              wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
              count_nxt  = count_r + 1'b1;
              if (filtered == urx_rb_pkg::CH_NEWLINE) begin
                line_nxt = 1'b1;
              end
            end
          end
          out_flag_nxt = line_nxt;
        end
        urx_rb_pkg::KIND_READ: begin
          if (!status.empty) begin
            // result follows once the stored character is read out
            mem_re        = 1'b1;
            rd_ptr_nxt    = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
            count_nxt     = count_r - 1'b1;
            out_valid_nxt = 1'b0;
          end
          out_flag_nxt = line_r;
        end
        urx_rb_pkg::KIND_ACK: begin
          out_flag_nxt = line_r;
          line_nxt     = 1'b0;
        end
        default: begin
          out_flag_nxt = line_r;
        end
      endcase
      out_fill_nxt = urx_rb_pkg::FILL_W'(count_nxt);
    end

    if (cmd.fetch_done) begin
      out_valid_nxt  = 1'b1;
      out_char_nxt   = rd_data_r;
      out_rvalid_nxt = 1'b1;
    end
  end

  // character store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= filtered;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      line_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r   <= out_char_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_flag_r   <= out_flag_nxt;
    out_fill_r   <= out_fill_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_char  = out_char_r;
  assign out_read_valid = out_rvalid_r;
  assign out_line_flag  = out_flag_r;
  assign out_fill_level = out_fill_r;
  assign out_overflow   = out_ovf_r;

endmodule

>>> hdl/uart_rx_filtering_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// uart_rx_filtering_ring_buffer_unit
// receive character ring buffer with cr drop, tab to space and line flag
// ----------------------------------------------------------------------------
// receive, acknowledge and empty read give a result in the cycle after accept
// a stored read loads rd_data_r, then its result is registered from ST_FETCH
// throughput: 1 request per cycle while results are taken, none in ST_FETCH
// the result register frees as a result is taken, so a request enters meanwhile
// reset: synchronous active low rst_n clears pointers, count, line flag, state
// the character store is not cleared; only written entries are ever read
module uart_rx_filtering_ring_buffer_unit (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_char,
  output logic       out_read_valid,
  output logic       out_line_flag,
  output logic [8:0] out_fill_level,
  output logic       out_overflow
);

`include "uart_rx_filtering_ring_buffer_unit_macros.svh"

  urx_rb_pkg::dp_cmd_t    cmd;
  urx_rb_pkg::dp_status_t status;

  // request qualifiers used by the checks below
  logic stored_read;
  logic other_req;
  logic ovf_result;
  logic at_full;

  // sequencer: decides when a request is taken and when a read completes
  urx_rb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: store, pointers, count, line flag and result register
  urx_rb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_kind        (in_kind),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_char  (out_read_char),
    .out_read_valid (out_read_valid),
    .out_line_flag  (out_line_flag),
    .out_fill_level (out_fill_level),
    .out_overflow   (out_overflow)
  );

  // read request taken while characters are stored
  assign stored_read = in_valid && in_ready && (in_kind == urx_rb_pkg::KIND_READ) &&
                       !status.empty;
  // any request taken that is not a read
  assign other_req   = in_valid && in_ready && (in_kind != urx_rb_pkg::KIND_READ);
  assign ovf_result  = out_valid && out_overflow;
  assign at_full     = (out_fill_level == urx_rb_pkg::FILL_W'(urx_rb_pkg::RING_DEPTH));

  // a stored read holds off new requests while the store is read
  `URX_ASSERT_NEXT(a_read_stalls, stored_read, !in_ready && !out_valid, "read did not stall")

  // any other request shows its result on the next cycle
  `URX_ASSERT_NEXT(a_result_next, other_req, out_valid, "result missing after request")

  // a dropped byte only happens with a full buffer
  `URX_ASSERT_NOW(a_ovf_full, ovf_result, at_full && !out_read_valid, "overflow not at full")

endmodule

>>> verif/tb_uart_rx_filtering_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// tb_uart_rx_filtering_ring_buffer_unit
// request level check of the uart rx ring buffer: filtering, line flag,
// full and empty handling and pointer wrap against a local buffer model,
// with random idle bursts on the request and result channels
// ----------------------------------------------------------------------------
module tb_uart_rx_filtering_ring_buffer_unit;

  // kind code the block does not use; it must still give a plain status result
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // generous bound on the whole run, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;

  // settle cycles after the last expected result
  localparam int SETTLE_CYCLES = 4;

  // one expected result of a request
  typedef struct packed {
    logic [7:0]                    ch;
    logic                          vld;
    logic                          flag;
    logic [urx_rb_pkg::FILL_W-1:0] fill;
    logic                          ovf;
  } rx_result_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [1:0] in_kind    = urx_rb_pkg::KIND_RECEIVE;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] out_read_char;
  logic       out_read_valid;
  logic       out_line_flag;
  logic [8:0] out_fill_level;
  logic       out_overflow;

  // buffer model state, updated as each request is accepted
  logic [7:0] char_mem [urx_rb_pkg::RING_DEPTH];
  int         wr_idx     = 0;
  int         rd_idx     = 0;
  int         stored     = 0;
  logic       line_avail = 1'b0;

  rx_result_t expected_results [$];
  int         error_count = 0;
  int         cycle_count = 0;

  // random idle bursts on both channels while set
  bit         idle_bursts = 1'b1;

  uart_rx_filtering_ring_buffer_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_char  (out_read_char),
    .out_read_valid (out_read_valid),
    .out_line_flag  (out_line_flag),
    .out_fill_level (out_fill_level),
    .out_overflow   (out_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // run bound, also catches a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // buffer model: one accepted request in, its result out
  function automatic rx_result_t predict_request(input logic [1:0] kind,
                                                 input logic [7:0] rx);
    rx_result_t r;
    logic [7:0] ch;
    r  = '0;
    ch = rx;
    case (kind)
      urx_rb_pkg::KIND_RECEIVE: begin
        // carriage return is dropped before anything else
        if (ch != urx_rb_pkg::CH_RETURN) begin
          if (ch == urx_rb_pkg::CH_TAB) ch = urx_rb_pkg::CH_SPACE;
          if (stored >= urx_rb_pkg::RING_DEPTH) begin
            // full: byte dropped, a dropped newline sets no flag
            r.ovf = 1'b1;
          end else begin
            char_mem[wr_idx] = ch;
            wr_idx = (wr_idx + 1) % urx_rb_pkg::RING_DEPTH;
            stored++;
            if (ch == urx_rb_pkg::CH_NEWLINE) line_avail = 1'b1;
          end
        end
        r.flag = line_avail;
      end
      urx_rb_pkg::KIND_READ: begin
        // empty read moves nothing and reports not valid
        if (stored != 0) begin
          r.ch  = char_mem[rd_idx];
          r.vld = 1'b1;
          rd_idx = (rd_idx + 1) % urx_rb_pkg::RING_DEPTH;
          stored--;
        end
        r.flag = line_avail;
      end
      urx_rb_pkg::KIND_ACK: begin
        // flag reported as it was before the clear
        r.flag = line_avail;
        line_avail = 1'b0;
      end
      default: begin
        r.flag = line_avail;
      end
    endcase
    r.fill = urx_rb_pkg::FILL_W'(stored);
    return r;
  endfunction

  // drive one request from a falling edge and hold it until accepted
  task automatic send_request(input logic [1:0] kind, input logic [7:0] rx);
    int gap;
    @(negedge clk);
    if (idle_bursts && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_byte <= rx;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_request(kind, rx));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // byte with a bias toward the characters the filter treats specially
  function automatic logic [7:0] pick_byte();
    logic [7:0] specials [6];
    specials = '{urx_rb_pkg::CH_TAB, urx_rb_pkg::CH_NEWLINE, urx_rb_pkg::CH_RETURN,
                 urx_rb_pkg::CH_SPACE, 8'h00, 8'hFF};
    if ($urandom_range(0, 3) == 0) return specials[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] pick_kind(input int recv_pct, input int read_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < recv_pct) return urx_rb_pkg::KIND_RECEIVE;
    if (r < recv_pct + read_pct) return urx_rb_pkg::KIND_READ;
    if (r < 97) return urx_rb_pkg::KIND_ACK;
    return KIND_UNUSED;
  endfunction

  // ----- tests -----

  // read, acknowledge and unused kind while nothing is stored
  task automatic test_empty_requests();
    send_request(urx_rb_pkg::KIND_READ, 8'hA5);
    send_request(urx_rb_pkg::KIND_ACK, 8'h5A);
    send_request(KIND_UNUSED, 8'hFF);
    send_request(urx_rb_pkg::KIND_READ, 8'h00);
    wait_for_results();
  endtask

  // cr drop, tab to space, byte extremes, newline flag and its acknowledge
  task automatic test_filtering();
    send_request(urx_rb_pkg::KIND_RECEIVE, urx_rb_pkg::CH_RETURN);
    send_request(urx_rb_pkg::KIND_RECEIVE, urx_rb_pkg::CH_TAB);
    send_request(urx_rb_pkg::KIND_RECEIVE, 8'h00);
    send_request(urx_rb_pkg::KIND_RECEIVE, 8'hFF);
    send_request(urx_rb_pkg::KIND_RECEIVE, 8'h41);
    send_request(urx_rb_pkg::KIND_RECEIVE, urx_rb_pkg::CH_NEWLINE);
    send_request(KIND_UNUSED, 8'h00);
    send_request(urx_rb_pkg::KIND_ACK, 8'hFF);
    send_request(urx_rb_pkg::KIND_ACK, 8'h00);
    send_request(urx_rb_pkg::KIND_RECEIVE, urx_rb_pkg::CH_SPACE);
    repeat (7) send_request(urx_rb_pkg::KIND_READ, 8'($urandom_range(0, 255)));
    wait_for_results();
  endtask

  // fill to the depth and try the overflow cases on full
  task automatic test_full_buffer();
    // printable bytes only, so the flag stays under control
    while (stored < urx_rb_pkg::RING_DEPTH)
      send_request(urx_rb_pkg::KIND_RECEIVE, 8'($urandom_range(33, 126)));
    send_request(urx_rb_pkg::KIND_ACK, 8'h00);
    send_request(urx_rb_pkg::KIND_RECEIVE, urx_rb_pkg::CH_NEWLINE);  // dropped, no flag
    send_request(urx_rb_pkg::KIND_RECEIVE, urx_rb_pkg::CH_RETURN);   // filtered, no overflow
    send_request(urx_rb_pkg::KIND_RECEIVE, urx_rb_pkg::CH_TAB);      // dropped on full
    send_request(KIND_UNUSED, 8'h13);
    send_request(urx_rb_pkg::KIND_READ, 8'h00);
    send_request(urx_rb_pkg::KIND_RECEIVE, urx_rb_pkg::CH_NEWLINE);  // fits again, flag set
    send_request(urx_rb_pkg::KIND_RECEIVE, 8'h7E);                   // full again
    wait_for_results();
  endtask

  // read everything back across the pointer wrap, then empty requests
  task automatic test_drain();
    while (stored > 0)
      send_request(urx_rb_pkg::KIND_READ, 8'($urandom_range(0, 255)));
    send_request(urx_rb_pkg::KIND_READ, 8'h00);
    send_request(urx_rb_pkg::KIND_ACK, 8'h00);
    wait_for_results();
  endtask

  // random request mix with a given share of receives and reads
  task automatic test_random_mix(input int count, input int recv_pct, input int read_pct);
    repeat (count) send_request(pick_kind(recv_pct, read_pct), pick_byte());
  endtask

  // ----- result side -----

  // result ready with random stall bursts
  always begin
    @(negedge clk);
    if (rst_n && idle_bursts && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  // compare every taken result with the oldest expectation
  always @(posedge clk) begin : check_results
    rx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_error("result with no request pending");
      end else begin
        want = expected_results.pop_front();
        if (out_read_char !== want.ch)
          report_error($sformatf("read_char got %0d want %0d", out_read_char, want.ch));
        if (out_read_valid !== want.vld)
          report_error($sformatf("read_valid got %0b want %0b", out_read_valid, want.vld));
        if (out_line_flag !== want.flag)
          report_error($sformatf("line_flag got %0b want %0b", out_line_flag, want.flag));
        if (out_fill_level !== want.fill)
          report_error($sformatf("fill_level got %0d want %0d", out_fill_level, want.fill));
        if (out_overflow !== want.ovf)
          report_error($sformatf("overflow got %0b want %0b", out_overflow, want.ovf));
      end
    end
  end

  // ----- sequence -----

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_requests();
    test_filtering();
    test_random_mix(25, 50, 35);
    wait_for_results();
    test_full_buffer();

    // drain and a short mix with no idling at all
    idle_bursts = 1'b0;
    test_drain();
    test_random_mix(20, 50, 35);
    wait_for_results();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> uart_rx_filtering_ring_buffer_unit.f
+incdir+hdl
hdl/urx_rb_pkg.sv
hdl/urx_rb_ctrl.sv
hdl/urx_rb_dp.sv
hdl/uart_rx_filtering_ring_buffer_unit.sv
verif/tb_uart_rx_filtering_ring_buffer_unit.sv
